/* rtl/pda_pkg.sv */
// Shared types and constants for the periodic density accumulator.
// Used by every module of the block; depends on nothing else.
package pda_pkg;

  localparam int MAX_DIM     = 32;
  localparam int CRD_W       = $clog2(MAX_DIM);
  localparam int ADDR_W      = 3 * CRD_W;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int DIM_W       = 6;
  localparam int COORD_W     = 7;
  localparam int SAMPLE_W    = 16;
  localparam int WEIGHT_W    = 16;
  localparam int ACC_W       = 32;
  localparam int INC_W       = 21;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    REG_GRID_NX = 2'd0,
    REG_GRID_NY = 2'd1,
    REG_GRID_NZ = 2'd2,
    REG_WEIGHT  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]           nx;
    logic [DIM_W-1:0]           ny;
    logic [DIM_W-1:0]           nz;
    logic signed [WEIGHT_W-1:0] weight;
  } cfg_t;

  // One item as it leaves the front end: folded address and rounded increment.
  typedef struct packed {
    logic                    vld;
    logic                    drop;
    logic [ADDR_W-1:0]       addr;
    logic signed [INC_W-1:0] inc;
  } item_t;

endpackage

/* rtl/pda_cfg.sv */
// Configuration register file behind the APB-style port.
// Depends on pda_pkg for the register map and the cfg_t bundle.
module pda_cfg import pda_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready,
  output cfg_t               cfg
);

  logic [DIM_W-1:0]           nx_r, ny_r, nz_r;
  logic signed [WEIGHT_W-1:0] weight_r;
  logic                       wr_en;
  reg_idx_t                   idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r     <= DIM_W'(MAX_DIM);
      ny_r     <= DIM_W'(MAX_DIM);
      nz_r     <= DIM_W'(MAX_DIM);
      weight_r <= WEIGHT_W'(4096);
    end else if (wr_en) begin
      unique case (idx)
        REG_GRID_NX: nx_r     <= cfg_pwdata[DIM_W-1:0];
        REG_GRID_NY: ny_r     <= cfg_pwdata[DIM_W-1:0];
        REG_GRID_NZ: nz_r     <= cfg_pwdata[DIM_W-1:0];
        REG_WEIGHT:  weight_r <= cfg_pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GRID_NX: cfg_prdata = PDATA_W'(nx_r);
      REG_GRID_NY: cfg_prdata = PDATA_W'(ny_r);
      REG_GRID_NZ: cfg_prdata = PDATA_W'(nz_r);
      REG_WEIGHT:  cfg_prdata = PDATA_W'(weight_r);
      default:     cfg_prdata = '0;
    endcase
  end

  assign cfg.nx     = nx_r;
  assign cfg.ny     = ny_r;
  assign cfg.nz     = nz_r;
  assign cfg.weight = weight_r;

endmodule

/* rtl/pda_front.sv */
// Front end: periodic folding, linear address and the scaled product.
// Four stages that advance together; depends on pda_pkg.
module pda_front import pda_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  adv,
  input  logic                  in_accept,
  input  logic [IN_TDATA_W-1:0] in_data,
  output item_t                 item
);

  typedef struct packed {
    logic             ok;
    logic [CRD_W-1:0] f;
  } fold_t;

  function automatic fold_t fold(input logic [COORD_W-1:0] c, input logic [DIM_W-1:0] n);
    logic signed [8:0] cs;
    logic signed [8:0] ns;
    logic signed [8:0] fs;
    fold_t             r;
    cs = 9'(signed'(c));
    ns = 9'(n);
    if (cs < 0) begin
      fs = cs + ns;
    end else if (cs >= ns) begin
      fs = cs - ns;
    end else begin
      fs = cs;
    end
    r.ok = (cs >= -ns) && (cs < (ns <<< 1));
    r.f  = fs[CRD_W-1:0];
    return r;
  endfunction

  function automatic logic dim_ok(input logic [DIM_W-1:0] n);
    return (n != '0) && (32'(n) <= MAX_DIM);
  endfunction

  // Stage 1: captured item.
  logic                        s1_vld_r;
  logic [COORD_W-1:0]          s1_x_r, s1_y_r, s1_z_r;
  logic signed [SAMPLE_W-1:0]  s1_pa_r, s1_pb_r;
  // Stage 2: address, drop flag and sample product.
  logic                        s2_vld_r, s2_drop_r;
  logic [ADDR_W-1:0]           s2_addr_r;
  logic signed [31:0]          s2_p_r;
  // Stage 3: weighted product.
  logic                        s3_vld_r, s3_drop_r;
  logic [ADDR_W-1:0]           s3_addr_r;
  logic signed [47:0]          s3_prod_r;
  // Stage 4: rounded increment.
  logic                        s4_vld_r, s4_drop_r;
  logic [ADDR_W-1:0]           s4_addr_r;
  logic signed [INC_W-1:0]     s4_inc_r;

  logic [2*DIM_W-1:0]          nyz_r;
  fold_t                       fx, fy, fz;
  logic                        drop_nxt;
  logic [ADDR_W-1:0]           addr_nxt;
  logic signed [31:0]          p_nxt;
  logic signed [47:0]          prod_nxt;
  logic signed [47:0]          rnd;

  assign fx       = fold(s1_x_r, cfg.nx);
  assign fy       = fold(s1_y_r, cfg.ny);
  assign fz       = fold(s1_z_r, cfg.nz);
  assign drop_nxt = !(dim_ok(cfg.nx) && dim_ok(cfg.ny) && dim_ok(cfg.nz)) ||
                    !fx.ok || !fy.ok || !fz.ok;
  assign addr_nxt = ADDR_W'(fx.f) * ADDR_W'(nyz_r) + ADDR_W'(fy.f) * ADDR_W'(cfg.nz) +
                    ADDR_W'(fz.f);
  assign p_nxt    = s1_pa_r * s1_pb_r;
  assign prod_nxt = s2_p_r * cfg.weight;
  // Round to nearest, ties up, while dropping 27 fraction bits.
  assign rnd      = s3_prod_r + 48'sd67108864;

  always_ff @(posedge clk) begin
    nyz_r <= cfg.ny * cfg.nz;
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_accept;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
    if (adv) begin
      s1_x_r    <= in_data[6:0];
      s1_y_r    <= in_data[13:7];
      s1_z_r    <= in_data[20:14];
      s1_pa_r   <= in_data[36:21];
      s1_pb_r   <= in_data[52:37];
      s2_drop_r <= drop_nxt;
      s2_addr_r <= addr_nxt;
      s2_p_r    <= p_nxt;
      s3_drop_r <= s2_drop_r;
      s3_addr_r <= s2_addr_r;
      s3_prod_r <= prod_nxt;
      s4_drop_r <= s3_drop_r;
      s4_addr_r <= s3_addr_r;
      s4_inc_r  <= rnd[47:27];
    end
  end

  assign item.vld  = s4_vld_r;
  assign item.drop = s4_drop_r;
  assign item.addr = s4_addr_r;
  assign item.inc  = s4_inc_r;

endmodule

/* rtl/pda_accum.sv */
// Density store with read-modify-write, write forwarding and the clearing pass.
// Holds the output register as well; depends on pda_pkg.
module pda_accum import pda_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  item_t                  item,
  output logic                   adv,
  output logic                   busy,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic signed [ACC_W-1:0] mem [STORE_DEPTH];
  logic signed [ACC_W-1:0] rd_data_r;

  logic                    clr_busy_r;
  logic [ADDR_W-1:0]       clr_cnt_r;

  logic                    s5_vld_r, s5_drop_r;
  logic [ADDR_W-1:0]       s5_addr_r;
  logic signed [INC_W-1:0] s5_inc_r;

  logic                    lw_vld_r;
  logic [ADDR_W-1:0]       lw_addr_r;
  logic signed [ACC_W-1:0] lw_data_r;

  logic                    out_vld_r, out_drop_r, out_sat_r;
  logic [ADDR_W-1:0]       out_addr_r;
  logic signed [ACC_W-1:0] out_acc_r;

  logic signed [ACC_W-1:0] old_val;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] sum_sat;
  logic                    sat;
  logic                    upd;
  logic                    rd_en;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [ACC_W-1:0] wr_data;

  assign adv   = !out_vld_r || out_tready;
  assign busy  = clr_busy_r;
  assign rd_en = adv && item.vld && !item.drop;
  assign upd   = adv && s5_vld_r && !s5_drop_r;

  // The read issued on the same edge as the previous write sees the old word.
  assign old_val = (lw_vld_r && lw_addr_r == s5_addr_r) ? lw_data_r : rd_data_r;
  assign sum     = {old_val[ACC_W-1], old_val} + (ACC_W+1)'(s5_inc_r);

  always_comb begin
    sat     = 1'b0;
    sum_sat = sum[ACC_W-1:0];
    if (sum[ACC_W:ACC_W-1] == 2'b01) begin
      sat     = 1'b1;
      sum_sat = ACC_MAX;
    end else if (sum[ACC_W:ACC_W-1] == 2'b10) begin
      sat     = 1'b1;
      sum_sat = ACC_MIN;
    end
  end

  assign wr_en   = clr_busy_r || upd;
  assign wr_addr = clr_busy_r ? clr_cnt_r : s5_addr_r;
  assign wr_data = clr_busy_r ? '0 : sum_sat;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[item.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      s5_vld_r   <= 1'b0;
      lw_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (32'(clr_cnt_r) == STORE_DEPTH - 1) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (adv) begin
        s5_vld_r  <= item.vld;
        out_vld_r <= s5_vld_r;
      end
      if (upd) begin
        lw_vld_r <= 1'b1;
      end
    end
    if (adv) begin
      s5_drop_r  <= item.drop;
      s5_addr_r  <= item.addr;
      s5_inc_r   <= item.inc;
      out_drop_r <= s5_drop_r;
      out_sat_r  <= !s5_drop_r && sat;
      out_addr_r <= s5_drop_r ? '0 : s5_addr_r;
      out_acc_r  <= s5_drop_r ? '0 : sum_sat;
    end
    if (upd) begin
      lw_addr_r <= s5_addr_r;
      lw_data_r <= sum_sat;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'({out_acc_r, out_addr_r});
  assign out_tuser  = {out_sat_r, out_drop_r};

`ifndef SYNTHESIS
  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s5_vld_r && !out_vld_r)
    else $error("item in flight during the clearing pass");

  a_clear_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> clr_cnt_r == '0)
    else $error("clearing pass ended before covering the whole store");

  a_drop_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_drop_r |-> out_acc_r == '0 && out_addr_r == '0 && !out_sat_r)
    else $error("dropped item carries a nonzero result");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_sat_r |-> out_acc_r == ACC_MAX || out_acc_r == ACC_MIN)
    else $error("saturated result is not at an accumulator limit");

  a_write_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_busy_r && wr_en |-> adv && s5_vld_r)
    else $error("store written without an item leaving the last stage");
`endif

endmodule

/* rtl/periodic_density_accumulator.sv */
// Top level of the periodic density accumulator: ties the register file,
// the folding/multiply front end and the store together. Depends on pda_pkg.
//
//   channel   direction  handshake                 contents
//   in_*      input      tvalid/tready             coordinates and two samples
//   out_*     output     tvalid/tready             address, sum, drop/sat flags
//   cfg_*     input      APB psel/penable/pready   grid_nx, ny, nz, weight
//
// One item per cycle is accepted unless the output stalls or the store is
// being cleared. A result passes four front-end stages, the store read stage
// and the output register, and the first of these is loaded at the transfer edge.
// Same-address items back to back are served by forwarding the last write.
// After reset the store is cleared one word a cycle, all 32768 words, with
// in_tready low. A stalled output holds the whole pipeline.
module periodic_density_accumulator import pda_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata: x_coord[6:0], y_coord[13:7], z_coord[20:14], psi_a[36:21], psi_b[52:37]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata: grid_address[14:0], accumulated[46:15]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: dropped[0], saturated[1]
  output logic [OUT_TUSER_W-1:0] out_tuser,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [PADDR_W-1:0]     cfg_paddr,
  input  logic [PDATA_W-1:0]     cfg_pwdata,
  output logic [PDATA_W-1:0]     cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t  cfg;
  item_t item;
  logic  adv;
  logic  busy;
  logic  in_accept;

  assign in_tready = adv && !busy;
  assign in_accept = in_tvalid && in_tready;

  pda_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pda_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .adv       (adv),
    .in_accept (in_accept),
    .in_data   (in_tdata),
    .item      (item)
  );

  pda_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .adv        (adv),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
